[sv/radix_prefixed_number_parser_unit_assert.svh]
// Assertion macros shared by the parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RADIX_PREFIXED_NUMBER_PARSER_UNIT_ASSERT_SVH
`define RADIX_PREFIXED_NUMBER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RPNP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rpnp assertion failed");

// Next-cycle implication, disabled during reset.
`define RPNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rpnp assertion failed");

`endif

[sv/rpnp_pkg.sv]
// Shared types and constants of the radix-prefixed number parser.
// No dependencies; imported by all parser modules.
package rpnp_pkg;

	// Width of the running value; results wrap modulo 2^VALUE_WIDTH.
	localparam int VALUE_WIDTH = 64;
	localparam int OUT_WIDTH   = 64;

	// Position counter saturates once the prefix window is past.
	localparam logic [1:0] POS_SAT = 2'd2;

	// ASCII codes used by the parser.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [7:0] CHAR_LB    = 8'h62;
	localparam logic [7:0] CHAR_LO    = 8'h6F;
	localparam logic [7:0] CHAR_LX    = 8'h78;

	// Item kinds on the input channel.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_OCT = 2'd2,
		RADIX_BIN = 2'd3
	} radix_t;

	// Decoded character: digit value and legality for the current radix.
	typedef struct packed {
		logic       legal;
		logic [3:0] digit;
	} digit_info_t;

	// Result of one literal as seen at its end beat.
	typedef struct packed {
		logic                   ok;
		logic [VALUE_WIDTH-1:0] value;
	} parse_res_t;

endpackage

[sv/rpnp_digit_decode.sv]
// Character to digit decoder with per-radix legality check.
// Depends on rpnp_pkg.
module rpnp_digit_decode (
	input  logic [7:0]           character,
	input  rpnp_pkg::radix_t     radix,
	output rpnp_pkg::digit_info_t info
);
	import rpnp_pkg::*;

	logic is_num;
	logic is_alpha;
	logic legal;

	// Class of the character
	assign is_num   = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
	assign is_alpha = ((character >= CHAR_UA) && (character <= CHAR_UF)) ||
		((character >= CHAR_LA) && (character <= CHAR_LF));

	// Letters A-F / a-f have low nibble 1..6, so value is nibble + 9
	assign info.digit = is_num ? character[3:0] : (character[3:0] + 4'd9);
	assign info.legal = legal;

	// Legality by radix
	always_comb begin
		unique case (radix)
			RADIX_HEX: legal = is_num || is_alpha;
			RADIX_OCT: legal = is_num && (character <= CHAR_SEVEN);
			RADIX_BIN: legal = is_num && (character <= CHAR_ONE);
			default:   legal = is_num;
		endcase
	end

endmodule

[sv/rpnp_core.sv]
// Parser state: prefix detection, radix, running value and error flag.
// Depends on rpnp_pkg, rpnp_digit_decode and the assertion macro header.
`include "radix_prefixed_number_parser_unit_assert.svh"

module rpnp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 kind,
	input  logic [7:0]           character,
	output rpnp_pkg::parse_res_t res
);
	import rpnp_pkg::*;

	logic [1:0]             position_q;
	logic                   first_zero_q;
	radix_t                 radix_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic                   bad_q;

	digit_info_t            info;
	logic                   is_prefix;
	logic [VALUE_WIDTH-1:0] scaled;
	radix_t                 prefix_radix;

	rpnp_digit_decode u_decode (
		.character (character),
		.radix     (radix_q),
		.info      (info)
	);

	// Prefix letter only counts as the second character after a leading zero
	assign is_prefix = (position_q == 2'd1) && first_zero_q &&
		((character == CHAR_LX) || (character == CHAR_LO) || (character == CHAR_LB));

	always_comb begin
		priority if (character == CHAR_LX) begin
			prefix_radix = RADIX_HEX;
		end else if (character == CHAR_LO) begin
			prefix_radix = RADIX_OCT;
		end else begin
			prefix_radix = RADIX_BIN;
		end
	end

	// acc * radix as shift-add
	always_comb begin
		unique case (radix_q)
			RADIX_HEX: scaled = acc_q << 4;
			RADIX_OCT: scaled = acc_q << 3;
			RADIX_BIN: scaled = acc_q << 1;
			default:   scaled = (acc_q << 3) + (acc_q << 1);
		endcase
	end

	// Result seen at the end beat
	assign res.ok    = !bad_q;
	assign res.value = bad_q ? '0 : acc_q;

	// State update, one beat per cycle while fire is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			first_zero_q <= 1'b0;
			radix_q      <= RADIX_DEC;
			acc_q        <= '0;
			bad_q        <= 1'b0;
		end else if (fire) begin
			if (kind == KIND_END) begin
				position_q   <= '0;
				first_zero_q <= 1'b0;
				radix_q      <= RADIX_DEC;
				acc_q        <= '0;
				bad_q        <= 1'b0;
			end else begin
				if (is_prefix) begin
					radix_q <= prefix_radix;
					acc_q   <= '0;
					bad_q   <= 1'b0;
				end else begin
					if (position_q == 2'd0) begin
						first_zero_q <= (character == CHAR_ZERO);
					end
					if (!info.legal) begin
						bad_q <= 1'b1;
					end else begin
						acc_q <= scaled + VALUE_WIDTH'(info.digit);
					end
				end
				if (position_q != POS_SAT) begin
					position_q <= position_q + 2'd1;
				end
			end
		end
	end

	`RPNP_ASSERT_NOW(a_pos_range, clk, arst_n, 1'b1, position_q != 2'd3)
	`RPNP_ASSERT_NOW(a_prefix_seen, clk, arst_n, radix_q != RADIX_DEC,
		first_zero_q && (position_q == POS_SAT))
	`RPNP_ASSERT_NEXT(a_end_clears, clk, arst_n, fire && (kind == KIND_END),
		(position_q == 2'd0) && (acc_q == '0) && !bad_q && (radix_q == RADIX_DEC))

endmodule

[sv/radix_prefixed_number_parser_unit.sv]
// Top level of the radix-prefixed number parser: input register, core, result register.
// Depends on rpnp_pkg, rpnp_core and the assertion macro header.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------
//   item    | item_valid / item_stall    | kind, character
//   result  | result_valid / result_stall| value[63:0], valid_res
//
// One beat per cycle while no stall holds the input register: each item is
// registered, then updates the parser state as it drains from the input
// register; an end item loads the result register as it clears the parser
// state. The state loop (shift-add on the running value) sets the rate.
// Reset clears all control and parser state. A held result stalls the item
// side only when an end item waits behind it; character beats keep flowing.
`include "radix_prefixed_number_parser_unit_assert.svh"

module radix_prefixed_number_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [7:0]  character,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [63:0] value,
	output logic        valid_res
);
	import rpnp_pkg::*;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  char_s1;
	logic        result_valid_q;
	logic [OUT_WIDTH-1:0] value_q;
	logic        valid_res_q;

	logic        out_free;
	logic        s1_fire;
	logic        item_fire;
	parse_res_t  res;

	// Stage 1 drains unless an end beat must wait for the result register
	assign out_free   = !result_valid_q || !result_stall;
	assign s1_fire    = valid_s1 && ((kind_s1 == KIND_CHAR) || out_free);
	assign item_stall = valid_s1 && !s1_fire;
	assign item_fire  = item_valid && !item_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			kind_s1 <= kind;
			char_s1 <= character;
		end
	end

	rpnp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (s1_fire),
		.kind      (kind_s1),
		.character (char_s1),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_fire && (kind_s1 == KIND_END)) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && (kind_s1 == KIND_END)) begin
			value_q     <= OUT_WIDTH'(res.value);
			valid_res_q <= res.ok;
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign valid_res    = valid_res_q;

	`RPNP_ASSERT_NOW(a_end_blocked, clk, arst_n,
		valid_s1 && (kind_s1 == KIND_END) && result_valid_q && result_stall, item_stall)
	`RPNP_ASSERT_NOW(a_invalid_zero, clk, arst_n, result_valid_q && !valid_res_q,
		value_q == '0)
	`RPNP_ASSERT_NEXT(a_end_lands, clk, arst_n, s1_fire && (kind_s1 == KIND_END),
		result_valid_q)

endmodule
